FILE: rtl/aminv_pkg.sv
// shared constants and types for the affine matrix inverse block
// no dependencies; imported by aminv_div and affine_matrix_inverse
`timescale 1ns / 1ps
`default_nettype none

package aminv_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned DIV_STEPS = 31;
  // divider depth: setup register, one register per quotient bit, saturation register
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  // top level: products, difference, magnitude, divider, translation products, sum, output
  localparam int unsigned NUM_STG   = 3 + DIV_LAT + 3;

  localparam logic signed [WORD_W-1:0] ONE_Q16  = 32'sh0001_0000;
  localparam logic signed [WORD_W-1:0] ZERO_Q16 = 32'sh0000_0000;
  localparam logic signed [WORD_W-1:0] MAX_Q16  = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] MIN_Q16  = 32'sh8000_0000;

  typedef logic signed [WORD_W-1:0] q16_t;

endpackage

`default_nettype wire

FILE: rtl/affine_matrix_inverse.sv
// top level of the 2D affine matrix inverse, signed Q16.16 in and out
// depends on aminv_pkg and four aminv_div lanes
`timescale 1ns / 1ps
`default_nettype none

// usage:
// s_axis carries one matrix per beat, m_axis one inverse per beat; tuser is the
// singular flag. cfg_valid/cfg_data writes det_epsilon (Q32.32 magnitude), always
// ready; write it while no beat is in flight.
// an input beat passes the multiply stages, the 31-stage quotient pipeline in each
// divider lane and the sum stages on its way to the output beat.
// throughput is one matrix per cycle. when the output beat is held by a low
// m_axis_tready, the whole pipeline freezes and s_axis_tready drops in the same
// cycle; nothing is lost or repeated. empty slots are not squeezed out.
// a determinant whose magnitude is at or below det_epsilon returns the identity
// with singular set.
// reset (rst, synchronous) clears the pipeline valid bits and sets det_epsilon to 0.

module affine_matrix_inverse (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // coef_a, coef_b, coef_c, coef_d, shift_x, shift_y, 32 bits each from bit 0
  input  wire logic [191:0] s_axis_tdata,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // inv_a, inv_b, inv_c, inv_d, inv_shift_x, inv_shift_y, 32 bits each from bit 0
  output      logic [191:0] m_axis_tdata,
  // singular
  output      logic         m_axis_tuser,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [31:0]  cfg_data
);
  import aminv_pkg::*;

  logic ce;
  logic [NUM_STG-1:0] vld;
  logic [WORD_W-1:0] det_epsilon;

  q16_t a0, b0, c0, d0, e0, f0;
  assign a0 = s_axis_tdata[31:0];
  assign b0 = s_axis_tdata[63:32];
  assign c0 = s_axis_tdata[95:64];
  assign d0 = s_axis_tdata[127:96];
  assign e0 = s_axis_tdata[159:128];
  assign f0 = s_axis_tdata[191:160];

  assign ce            = !vld[NUM_STG-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = vld[NUM_STG-1];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= '0;
    end else if (cfg_valid) begin
      det_epsilon <= cfg_data;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NUM_STG-2:0], s_axis_tvalid};
    end
  end

  // stage 1: determinant products
  logic signed [PROD_W-1:0] p1, p2;
  q16_t a1, b1, c1, d1, e1, f1;
  always_ff @(posedge clk) begin
    if (ce) begin
      p1 <= a0 * d0;
      p2 <= b0 * c0;
      a1 <= a0; b1 <= b0; c1 <= c0; d1 <= d0; e1 <= e0; f1 <= f0;
    end
  end

  // stage 2: exact difference
  logic signed [PROD_W:0] det2;
  q16_t a2, b2, c2, d2, e2, f2;
  always_ff @(posedge clk) begin
    if (ce) begin
      det2 <= {p1[PROD_W-1], p1} - {p2[PROD_W-1], p2};
      a2 <= a1; b2 <= b1; c2 <= c1; d2 <= d1; e2 <= e1; f2 <= f1;
    end
  end

  // stage 3: sign and magnitude of the determinant, numerator magnitudes
  logic              dneg3;
  logic [PROD_W-1:0] dmag3;
  logic [PROD_W:0]   det_abs;
  logic [WORD_W-1:0] ma3, mb3, mc3, md3;
  logic              na3, nb3, nc3, nd3;
  q16_t e3, f3;
  assign det_abs = det2[PROD_W] ? -det2 : det2;
  always_ff @(posedge clk) begin
    if (ce) begin
      dneg3 <= det2[PROD_W];
      dmag3 <= det_abs[PROD_W-1:0];
      md3 <= d2[WORD_W-1] ? -d2 : d2;
      nd3 <= d2[WORD_W-1];
      ma3 <= a2[WORD_W-1] ? -a2 : a2;
      na3 <= a2[WORD_W-1];
      // numerators -b and -c
      mb3 <= b2[WORD_W-1] ? -b2 : b2;
      nb3 <= !b2[WORD_W-1] && (b2 != ZERO_Q16);
      mc3 <= c2[WORD_W-1] ? -c2 : c2;
      nc3 <= !c2[WORD_W-1] && (c2 != ZERO_Q16);
      e3 <= e2; f3 <= f2;
    end
  end

  // divider lanes for d, -b, -c, a
  q16_t qa, qb, qc, qd;
  aminv_div u_div_a (.clk, .ce, .nmag(md3), .nneg(nd3), .dneg(dneg3), .dmag(dmag3), .quo(qa));
  aminv_div u_div_b (.clk, .ce, .nmag(mb3), .nneg(nb3), .dneg(dneg3), .dmag(dmag3), .quo(qb));
  aminv_div u_div_c (.clk, .ce, .nmag(mc3), .nneg(nc3), .dneg(dneg3), .dmag(dmag3), .quo(qc));
  aminv_div u_div_d (.clk, .ce, .nmag(ma3), .nneg(na3), .dneg(dneg3), .dmag(dmag3), .quo(qd));

  // delay line for translation terms and the singular flag beside the dividers
  q16_t ed [0:DIV_LAT-1];
  q16_t fd [0:DIV_LAT-1];
  logic sd [0:DIV_LAT-1];
  always_ff @(posedge clk) begin
    if (ce) begin
      ed[0] <= e3;
      fd[0] <= f3;
      sd[0] <= dmag3 <= {{(PROD_W-WORD_W){1'b0}}, det_epsilon};
      for (int k = 1; k < DIV_LAT; k++) begin
        ed[k] <= ed[k-1];
        fd[k] <= fd[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  // translation products on the saturated inverse terms
  logic signed [PROD_W-1:0] pea, pfc, peb, pfd;
  q16_t ia5, ib5, ic5, id5;
  logic s5;
  always_ff @(posedge clk) begin
    if (ce) begin
      pea <= ed[DIV_LAT-1] * qa;
      pfc <= fd[DIV_LAT-1] * qc;
      peb <= ed[DIV_LAT-1] * qb;
      pfd <= fd[DIV_LAT-1] * qd;
      ia5 <= qa; ib5 <= qb; ic5 <= qc; id5 <= qd;
      s5 <= sd[DIV_LAT-1];
    end
  end

  // exact Q32.32 sums
  logic signed [PROD_W+1:0] sx, sy;
  q16_t ia6, ib6, ic6, id6;
  logic s6;
  always_ff @(posedge clk) begin
    if (ce) begin
      sx <= -$signed({{2{pea[PROD_W-1]}}, pea}) - $signed({{2{pfc[PROD_W-1]}}, pfc});
      sy <= -$signed({{2{peb[PROD_W-1]}}, peb}) - $signed({{2{pfd[PROD_W-1]}}, pfd});
      ia6 <= ia5; ib6 <= ib5; ic6 <= ic5; id6 <= id5;
      s6 <= s5;
    end
  end

  // shift down with truncation toward zero, then saturate
  function automatic q16_t reduce_q16(input logic signed [PROD_W+1:0] s);
    logic signed [PROD_W+1:0] adj;
    logic signed [PROD_W+1:0] t;
    adj = s + (s[PROD_W+1] ? (PROD_W+2)'(16'hffff) : '0);
    t   = adj >>> 16;
    if (t > $signed({{(PROD_W-WORD_W+2){1'b0}}, MAX_Q16})) begin
      return MAX_Q16;
    end else if (t < $signed({{(PROD_W-WORD_W+2){1'b1}}, MIN_Q16})) begin
      return MIN_Q16;
    end
    return t[WORD_W-1:0];
  endfunction

  // output register, identity when singular
  always_ff @(posedge clk) begin
    if (ce) begin
      if (s6) begin
        m_axis_tdata <= {ZERO_Q16, ZERO_Q16, ONE_Q16, ZERO_Q16, ZERO_Q16, ONE_Q16};
      end else begin
        m_axis_tdata <= {reduce_q16(sy), reduce_q16(sx), id6, ic6, ib6, ia6};
      end
      m_axis_tuser <= s6;
    end
  end

`ifndef SYNTHESIS
  a_singular_identity: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata == {ZERO_Q16, ZERO_Q16, ONE_Q16, ZERO_Q16, ZERO_Q16, ONE_Q16})
    else $error("singular beat without identity matrix");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/aminv_div.sv
// pipelined restoring divider: (nmag << 32) / dmag, signed and saturated to Q16.16
// depends on aminv_pkg; one quotient bit per register stage
`timescale 1ns / 1ps
`default_nettype none

module aminv_div (
  input  wire logic                               clk,
  input  wire logic                               ce,
  input  wire logic [aminv_pkg::WORD_W-1:0]       nmag,
  input  wire logic                               nneg,
  input  wire logic                               dneg,
  input  wire logic [aminv_pkg::PROD_W-1:0]       dmag,
  output      logic signed [aminv_pkg::WORD_W-1:0] quo
);
  import aminv_pkg::*;

  logic [PROD_W-1:0]    rem  [0:DIV_STEPS];
  logic [PROD_W-1:0]    dv   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qb   [0:DIV_STEPS];
  logic                 ovf  [0:DIV_STEPS];
  logic                 neg  [0:DIV_STEPS];

  // setup: quotient at or above 2^31 saturates, so check 2*nmag against dmag
  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= {{(PROD_W-WORD_W-1){1'b0}}, nmag, 1'b0};
      dv[0]  <= dmag;
      qb[0]  <= '0;
      ovf[0] <= {{(PROD_W-WORD_W){1'b0}}, nmag, 1'b0} >= {1'b0, dmag};
      neg[0] <= nneg ^ dneg;
    end
  end

  // one shift, compare and subtract per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [PROD_W:0] r2;
    logic [PROD_W:0] diff;
    logic            ge;
    assign r2   = {rem[k-1], 1'b0};
    assign diff = r2 - {1'b0, dv[k-1]};
    assign ge   = r2 >= {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k] <= ge ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
        dv[k]  <= dv[k-1];
        qb[k]  <= {qb[k-1][DIV_STEPS-2:0], ge};
        ovf[k] <= ovf[k-1];
        neg[k] <= neg[k-1];
      end
    end
  end

  // apply sign after the division and saturate
  always_ff @(posedge clk) begin
    if (ce) begin
      if (ovf[DIV_STEPS]) begin
        quo <= neg[DIV_STEPS] ? MIN_Q16 : MAX_Q16;
      end else if (neg[DIV_STEPS]) begin
        quo <= -$signed({1'b0, qb[DIV_STEPS]});
      end else begin
        quo <= $signed({1'b0, qb[DIV_STEPS]});
      end
    end
  end

endmodule

`default_nettype wire
